### rtl/cvq_pkg.sv
`default_nettype none

package cvq_pkg;

    // Pool geometry
    localparam int NUM_VARS   = 16;
    localparam int RING_DEPTH = 16;

    localparam int VAR_W  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int ADDR_W = $clog2(NUM_VARS * RING_DEPTH);

    // Field widths
    localparam int MODE_W   = 3;
    localparam int CV_W     = 8;
    localparam int TASK_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ALLOC_W  = 4;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SIGNAL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BCAST  = 3'd4;

    // Response status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFREE  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ALLOC_W-1:0]  alloc_id;
        logic [TASK_W-1:0]   woken_task;
        logic                woken_valid;
        logic                dropped;
        logic                last;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/cvq_if.sv
`default_nettype none

// Request channel: one transaction per command.
interface cvq_req_if;
    import cvq_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CV_W-1:0]   cv_id;
    logic [TASK_W-1:0] task_id;

    modport source (output valid, output mode, output cv_id, output task_id, input ready);
    modport sink   (input valid, input mode, input cv_id, input task_id, output ready);
endinterface

// Response channel: one or more transactions per command.
interface cvq_rsp_if;
    import cvq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ALLOC_W-1:0]  alloc_id;
    logic [TASK_W-1:0]   woken_task;
    logic                woken_valid;
    logic                dropped;
    logic                last;

    modport source (output valid, output status, output alloc_id, output woken_task,
                    output woken_valid, output dropped, output last, input ready);
    modport sink   (input valid, input status, input alloc_id, input woken_task,
                    input woken_valid, input dropped, input last, output ready);
endinterface

`default_nettype wire

### rtl/condition_wait_queue_pool.sv
// Response: free, wait, rejects and empty-ring signal/broadcast respond the cycle after acceptance;
//   signal/broadcast with waiters go through a RAM read first; alloc walks one used bit/step.
// Throughput: one command at a time; request ready returns the cycle after the last response
//   transaction is taken. Broadcast delivers its waiters one at a time (RAM read, then output).
// Reset: synchronous, active low; clears the used bits and ring pointers. Waiter RAM is not
//   cleared and needs no clearing pass, so the block is ready right after reset.
`default_nettype none

module condition_wait_queue_pool (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cvq_req_if.sink   i_req,
    cvq_rsp_if.source o_rsp
);
    import cvq_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request
    localparam logic [1:0] S_SCAN = 2'd1;  // alloc: walk used bits one per cycle
    localparam logic [1:0] S_RD   = 2'd2;  // waiter RAM read data arriving
    localparam logic [1:0] S_OUT  = 2'd3;  // response held until taken

    logic [1:0] r_state, n_state;

    // Per-variable control state, indexed by the latched or incoming id
    logic [NUM_VARS-1:0] r_in_use, n_in_use;
    logic [PTR_W-1:0]    r_head [NUM_VARS];
    logic [PTR_W-1:0]    n_head [NUM_VARS];
    logic [PTR_W-1:0]    r_tail [NUM_VARS];
    logic [PTR_W-1:0]    n_tail [NUM_VARS];

    // Command context and scan index
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [VAR_W-1:0]  r_cv, n_cv;
    logic [VAR_W-1:0]  r_idx, n_idx;

    // Output register
    t_rsp r_rsp, n_rsp;

    // Waiter RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [TASK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [TASK_W-1:0] ram_rdata;

    logic             req_acc;
    logic             rsp_acc;
    logic [VAR_W-1:0] in_cv;
    logic [VAR_W-1:0] rd_cv;
    logic             cv_bad;
    logic [PTR_W-1:0] tail_nx;
    logic [PTR_W-1:0] head_nx;

    // Ring pointer step, wraps at RING_DEPTH
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    // Waiter slot of a variable: rows of RING_DEPTH entries
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [VAR_W-1:0] v,
                                                    input logic [PTR_W-1:0] p);
        logic [ADDR_W-1:0] res;
        res = ADDR_W'(ADDR_W'(v) * ADDR_W'(RING_DEPTH) + ADDR_W'(p));
        return res;
    endfunction

    assign req_acc = i_req.valid && i_req.ready;
    assign rsp_acc = o_rsp.valid && o_rsp.ready;

    // Index bits only; range check covers the upper bits
    assign in_cv  = i_req.cv_id[VAR_W-1:0];
    assign cv_bad = ({1'b0, i_req.cv_id} >= (CV_W + 1)'(NUM_VARS)) || !r_in_use[in_cv];

    // Reads come from the incoming id when idle, else from the latched one
    assign rd_cv   = (r_state == S_IDLE) ? in_cv : r_cv;
    assign tail_nx = ptr_next(r_tail[in_cv]);
    assign head_nx = ptr_next(r_head[r_cv]);

    assign ram_waddr = slot_addr(in_cv, r_tail[in_cv]);
    assign ram_wdata = i_req.task_id;
    assign ram_raddr = slot_addr(rd_cv, r_head[rd_cv]);

    cvq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (NUM_VARS * RING_DEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_in_use = r_in_use;
        n_head   = r_head;
        n_tail   = r_tail;
        n_mode   = r_mode;
        n_cv     = r_cv;
        n_idx    = r_idx;
        n_rsp    = r_rsp;
        ram_we   = 1'b0;
        ram_re   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_mode     = i_req.mode;
                    n_cv       = in_cv;
                    n_rsp      = '0;
                    n_rsp.last = 1'b1;
                    n_state    = S_OUT;
                    if (i_req.mode == MODE_ALLOC) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else if (i_req.mode > MODE_BCAST || cv_bad) begin
                        n_rsp.status = STAT_INVALID;
                    end else begin
                        case (i_req.mode)
                            MODE_FREE: begin
                                n_in_use[in_cv] = 1'b0;
                            end
                            MODE_WAIT: begin
                                // Full ring: one slot always stays empty
                                if (tail_nx == r_head[in_cv]) begin
                                    n_rsp.dropped = 1'b1;
                                end else begin
                                    ram_we        = 1'b1;
                                    n_tail[in_cv] = tail_nx;
                                end
                            end
                            default: begin
                                // signal / broadcast; empty ring answers at once
                                if (r_head[in_cv] != r_tail[in_cv]) begin
                                    ram_re  = 1'b1;
                                    n_state = S_RD;
                                end
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (!r_in_use[r_idx]) begin
                    n_in_use[r_idx] = 1'b1;
                    n_head[r_idx]   = '0;
                    n_tail[r_idx]   = '0;
                    n_rsp.alloc_id  = ALLOC_W'(r_idx);
                    n_state         = S_OUT;
                end else if (r_idx == VAR_W'(NUM_VARS - 1)) begin
                    n_rsp.status = STAT_NOFREE;
                    n_state      = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RD: begin
                n_rsp.status      = STAT_OK;
                n_rsp.alloc_id    = '0;
                n_rsp.woken_task  = ram_rdata;
                n_rsp.woken_valid = 1'b1;
                n_rsp.dropped     = 1'b0;
                n_rsp.last        = (r_mode == MODE_SIGNAL) || (head_nx == r_tail[r_cv]);
                n_head[r_cv]      = head_nx;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (rsp_acc) begin
                    // Broadcast keeps draining until the ring is empty
                    if (r_mode == MODE_BCAST && r_rsp.woken_valid && !r_rsp.last) begin
                        ram_re  = 1'b1;
                        n_state = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            for (int i = 0; i < NUM_VARS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_head   <= n_head;
            r_tail   <= n_tail;
        end
    end

    // Payload and context registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_cv   <= n_cv;
        r_idx  <= n_idx;
        r_rsp  <= n_rsp;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.alloc_id    = r_rsp.alloc_id;
    assign o_rsp.woken_task  = r_rsp.woken_task;
    assign o_rsp.woken_valid = r_rsp.woken_valid;
    assign o_rsp.dropped     = r_rsp.dropped;
    assign o_rsp.last        = r_rsp.last;

endmodule

`default_nettype wire

### rtl/cvq_ram.sv
`default_nettype none

module cvq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/cvq_chk.sv
`default_nettype none

module cvq_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_req_valid,
    input wire logic                         i_req_ready,
    input wire logic                         i_rsp_valid,
    input wire logic                         i_rsp_ready,
    input wire logic [cvq_pkg::STATUS_W-1:0] i_rsp_status,
    input wire logic [cvq_pkg::TASK_W-1:0]   i_rsp_woken_task,
    input wire logic                         i_rsp_woken_valid,
    input wire logic                         i_rsp_dropped,
    input wire logic                         i_rsp_last
);
    import cvq_pkg::*;

    // One command in flight: never ready while a response is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !i_rsp_valid)
        else $error("request ready while response pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("ready right after accepting a request");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != STAT_OK) |->
            (i_rsp_last && !i_rsp_woken_valid && !i_rsp_dropped))
        else $error("error response with payload flags");

    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_woken_valid) |-> (i_rsp_woken_task == '0))
        else $error("woken task set without woken valid");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_woken_task)))
        else $error("stalled response dropped or changed");

endmodule

bind condition_wait_queue_pool cvq_chk u_cvq_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_woken_task  (o_rsp.woken_task),
    .i_rsp_woken_valid (o_rsp.woken_valid),
    .i_rsp_dropped     (o_rsp.dropped),
    .i_rsp_last        (o_rsp.last)
);

`default_nettype wire

### bench/tb.sv
module tb;
    import cvq_pkg::*;

    // Undefined mode codes; the block must reject them.
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI  = 3'd7;

    localparam int RAND_ITEMS    = 360;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_AT       = 300;     // accepted command count that starts the long stall
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE1_END    = 130;
    localparam int PHASE2_END    = 260;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [CV_W-1:0]   cv;
        logic [TASK_W-1:0] tid;
        bit                typed;   // expected response written in the row
        t_rsp              exp;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    cvq_req_if req_if ();
    cvq_rsp_if rsp_if ();

    condition_wait_queue_pool DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the pool: used bits, ring pointers and waiter slots.
    bit                 cv_used [NUM_VARS];
    logic [PTR_W-1:0]   wq_head [NUM_VARS];
    logic [PTR_W-1:0]   wq_tail [NUM_VARS];
    logic [TASK_W-1:0]  wq_slot [NUM_VARS*RING_DEPTH];

    // Response transactions still owed by the block, oldest first.
    t_rsp owed_responses [$];

    int   mismatches    = 0;
    int   cmds_accepted = 0;
    int   cycle_count   = 0;

    // Written with the request at the falling edge, read on acceptance.
    bit   cur_typed = 1'b0;
    t_rsp cur_exp   = '0;

    int   hold_left = 0;
    bit   hold_done = 1'b0;

    function automatic t_rsp mk_rsp(logic [STATUS_W-1:0] st, logic [ALLOC_W-1:0] aid,
                                    logic [TASK_W-1:0] wt, logic wv, logic dr, logic lst);
        t_rsp r;
        r.status      = st;
        r.alloc_id    = aid;
        r.woken_task  = wt;
        r.woken_valid = wv;
        r.dropped     = dr;
        r.last        = lst;
        return r;
    endfunction

    // Applies one command to the shadow pool and queues the responses it owes.
    function automatic void cv_pool_predict(logic [MODE_W-1:0] m, logic [CV_W-1:0] cv,
                                            logic [TASK_W-1:0] tid);
        logic [PTR_W-1:0] nxt;
        logic [TASK_W-1:0] woken;
        int v;
        if (m == MODE_ALLOC) begin
            // lowest free entry wins; its ring starts empty
            for (v = 0; v < NUM_VARS; v++) begin
                if (!cv_used[v]) begin
                    cv_used[v] = 1'b1;
                    wq_head[v] = '0;
                    wq_tail[v] = '0;
                    owed_responses.push_back(mk_rsp(STAT_OK, ALLOC_W'(v), '0, 0, 0, 1));
                    return;
                end
            end
            owed_responses.push_back(mk_rsp(STAT_NOFREE, '0, '0, 0, 0, 1));
            return;
        end
        if (m > MODE_BCAST || cv >= NUM_VARS || !cv_used[cv]) begin
            owed_responses.push_back(mk_rsp(STAT_INVALID, '0, '0, 0, 0, 1));
            return;
        end
        v = cv;
        case (m)
            MODE_FREE: begin
                cv_used[v] = 1'b0;
                owed_responses.push_back(mk_rsp(STAT_OK, '0, '0, 0, 0, 1));
            end
            MODE_WAIT: begin
                // one slot stays empty, so a ring holds RING_DEPTH-1 ids
                nxt = PTR_W'(wq_tail[v] + 1);
                if (nxt == wq_head[v]) begin
                    owed_responses.push_back(mk_rsp(STAT_OK, '0, '0, 0, 1, 1));
                end else begin
                    wq_slot[v*RING_DEPTH + wq_tail[v]] = tid;
                    wq_tail[v] = nxt;
                    owed_responses.push_back(mk_rsp(STAT_OK, '0, '0, 0, 0, 1));
                end
            end
            MODE_SIGNAL: begin
                if (wq_head[v] == wq_tail[v]) begin
                    owed_responses.push_back(mk_rsp(STAT_OK, '0, '0, 0, 0, 1));
                end else begin
                    woken = wq_slot[v*RING_DEPTH + wq_head[v]];
                    wq_head[v] = PTR_W'(wq_head[v] + 1);
                    owed_responses.push_back(mk_rsp(STAT_OK, '0, woken, 1, 0, 1));
                end
            end
            default: begin
                // broadcast drains the ring oldest first; last marks the final id
                if (wq_head[v] == wq_tail[v])
                    owed_responses.push_back(mk_rsp(STAT_OK, '0, '0, 0, 0, 1));
                while (wq_head[v] != wq_tail[v]) begin
                    woken = wq_slot[v*RING_DEPTH + wq_head[v]];
                    wq_head[v] = PTR_W'(wq_head[v] + 1);
                    owed_responses.push_back(mk_rsp(STAT_OK, '0, woken, 1, 0,
                                                    wq_head[v] == wq_tail[v]));
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, int exp, int act);
        if (exp != act) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        end
    endfunction

    // Idle mix: sender light / receiver heavy, then swapped, then no idling.
    function automatic int sender_idle_pct();
        if (cmds_accepted < PHASE1_END) return 20;
        if (cmds_accepted < PHASE2_END) return 45;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (cmds_accepted < PHASE1_END) return 45;
        if (cmds_accepted < PHASE2_END) return 20;
        return 0;
    endfunction

    function automatic bit pick_used(output int idx);
        int cand [$];
        idx = 0;
        for (int v = 0; v < NUM_VARS; v++)
            if (cv_used[v]) cand.push_back(v);
        if (cand.size() == 0) return 1'b0;
        idx = cand[$urandom_range(cand.size() - 1)];
        return 1'b1;
    endfunction

    function automatic int ring_fill(int v);
        return int'(PTR_W'(wq_tail[v] - wq_head[v]));
    endfunction

    // Offers one command from a falling edge and returns at the falling edge
    // after the transaction is taken.
    task automatic send_cmd(logic [MODE_W-1:0] m, logic [CV_W-1:0] cv,
                            logic [TASK_W-1:0] tid, bit typed, t_rsp exp);
        while ($urandom_range(99) < sender_idle_pct()) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.mode    = m;
        req_if.cv_id   = cv;
        req_if.task_id = tid;
        cur_typed      = typed;
        cur_exp        = exp;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off so that the
    // block sits on a response while the next request waits at its input.
    always @(negedge i_clk) begin
        if (!hold_done && cmds_accepted >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
        end else begin
            rsp_if.ready = ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Scoreboard: predict on each accepted request, compare each response.
    always @(posedge i_clk) begin
        t_rsp exp;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_responses.size() == 0) begin
                    mismatches++;
                    $display("%0t: response with nothing expected, expected none, %s %0d %s %0d",
                             $time, "actual status", rsp_if.status, "task",
                             rsp_if.woken_task);
                end else begin
                    exp = owed_responses.pop_front();
                    check_field("status",      exp.status,      rsp_if.status);
                    check_field("alloc_id",    exp.alloc_id,    rsp_if.alloc_id);
                    check_field("woken_task",  exp.woken_task,  rsp_if.woken_task);
                    check_field("woken_valid", exp.woken_valid, rsp_if.woken_valid);
                    check_field("dropped",     exp.dropped,     rsp_if.dropped);
                    check_field("last",        exp.last,        rsp_if.last);
                end
            end
            if (req_if.valid && req_if.ready) begin
                cv_pool_predict(req_if.mode, req_if.cv_id, req_if.task_id);
                // rows with a written-out answer replace the single predicted one
                if (cur_typed) begin
                    void'(owed_responses.pop_back());
                    owed_responses.push_back(cur_exp);
                end
                cmds_accepted <= cmds_accepted + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_dir_row dir_rows [$];
        t_dir_row row;
        t_rsp     bad;
        int       rand_sent;
        int       pick;
        int       v;
        int       n;

        rand_sent = 0;
        bad       = mk_rsp(STAT_INVALID, '0, '0, 0, 0, 1);

        req_if.valid   = 1'b0;
        req_if.mode    = MODE_ALLOC;
        req_if.cv_id   = '0;
        req_if.task_id = '0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: rejects right after reset, unknown modes, first allocs,
        // empty signal/broadcast, id extremes, reuse after free.
        dir_rows = '{
            '{MODE_SIGNAL,    8'd0,   8'd0,   1, bad},
            '{MODE_BCAST,     8'd15,  8'd0,   1, bad},
            '{MODE_WAIT,      8'd255, 8'd255, 1, bad},
            '{MODE_FREE,      8'd0,   8'd0,   1, bad},
            '{MODE_UNDEF_LO,  8'd0,   8'd0,   1, bad},
            '{MODE_UNDEF_HI,  8'd0,   8'd0,   1, bad},
            '{MODE_ALLOC,     8'd0,   8'd0,   1, mk_rsp(STAT_OK, 4'd0, '0, 0, 0, 1)},
            '{MODE_ALLOC,     8'd255, 8'd255, 1, mk_rsp(STAT_OK, 4'd1, '0, 0, 0, 1)},
            '{MODE_SIGNAL,    8'd0,   8'd0,   1, mk_rsp(STAT_OK, '0, '0, 0, 0, 1)},
            '{MODE_BCAST,     8'd0,   8'd0,   1, mk_rsp(STAT_OK, '0, '0, 0, 0, 1)},
            '{MODE_WAIT,      8'd0,   8'd255, 1, mk_rsp(STAT_OK, '0, '0, 0, 0, 1)},
            '{MODE_WAIT,      8'd0,   8'd0,   1, mk_rsp(STAT_OK, '0, '0, 0, 0, 1)},
            '{MODE_WAIT,      8'd0,   8'h5A,  0, '0},
            '{MODE_WAIT,      8'd1,   8'hA5,  0, '0},
            '{MODE_SIGNAL,    8'd0,   8'd0,   0, '0},
            '{MODE_BCAST,     8'd0,   8'd0,   0, '0},
            '{MODE_SIGNAL,    8'd1,   8'd0,   0, '0},
            '{MODE_FREE,      8'd1,   8'd0,   1, mk_rsp(STAT_OK, '0, '0, 0, 0, 1)},
            '{MODE_WAIT,      8'd1,   8'd3,   1, bad},
            '{MODE_ALLOC,     8'd0,   8'd0,   1, mk_rsp(STAT_OK, 4'd1, '0, 0, 0, 1)},
            '{MODE_WAIT,      8'd16,  8'd7,   1, bad},
            '{MODE_WAIT,      8'd15,  8'd7,   1, bad},
            '{MODE_UNDEF_MID, 8'd0,   8'd0,   1, bad},
            '{MODE_BCAST,     8'd1,   8'd0,   1, mk_rsp(STAT_OK, '0, '0, 0, 0, 1)}
        };

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_cmd(row.mode, row.cv, row.tid, row.typed, row.exp);
        end

        // Random part: mostly commands on live variables, with bursts that
        // fill a ring past full or drain the pool, plus noise and bad ids.
        while (rand_sent < RAND_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_cmd(MODE_W'($urandom_range(7)), CV_W'($urandom_range(255)),
                         TASK_W'($urandom_range(255)), 0, '0);
                rand_sent++;
            end else if (pick < 22) begin
                send_cmd(MODE_ALLOC, CV_W'($urandom_range(255)),
                         TASK_W'($urandom_range(255)), 0, '0);
                rand_sent++;
            end else if (pick < 25) begin
                // allocate until the pool runs dry, one alloc past it
                n = 1;
                for (int k = 0; k < NUM_VARS; k++)
                    if (!cv_used[k]) n++;
                repeat (n) begin
                    send_cmd(MODE_ALLOC, '0, '0, 0, '0);
                    rand_sent++;
                end
            end else if (pick < 28 && pick_used(v)) begin
                // fill a ring, overflow it by one or two, often drain it whole
                n = RING_DEPTH - 1 - ring_fill(v) + $urandom_range(1, 2);
                repeat (n) begin
                    send_cmd(MODE_WAIT, CV_W'(v), TASK_W'($urandom_range(255)), 0, '0);
                    rand_sent++;
                end
                if ($urandom_range(1)) begin
                    send_cmd(MODE_BCAST, CV_W'(v), TASK_W'($urandom_range(255)), 0, '0);
                    rand_sent++;
                end
            end else if (pick < 34) begin
                // out-of-range id, or any low id that may well be unused
                send_cmd(MODE_W'($urandom_range(MODE_FREE, MODE_BCAST)),
                         CV_W'($urandom_range(1) ? $urandom_range(NUM_VARS, 255)
                                                 : $urandom_range(NUM_VARS - 1)),
                         TASK_W'($urandom_range(255)), 0, '0);
                rand_sent++;
            end else if (!pick_used(v)) begin
                send_cmd(MODE_ALLOC, '0, '0, 0, '0);
                rand_sent++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 10)
                    send_cmd(MODE_FREE, CV_W'(v), TASK_W'($urandom_range(255)), 0, '0);
                else if (pick < 62)
                    send_cmd(MODE_WAIT, CV_W'(v), TASK_W'($urandom_range(255)), 0, '0);
                else if (pick < 86)
                    send_cmd(MODE_SIGNAL, CV_W'(v), TASK_W'($urandom_range(255)), 0, '0);
                else
                    send_cmd(MODE_BCAST, CV_W'(v), TASK_W'($urandom_range(255)), 0, '0);
                rand_sent++;
            end
        end
        req_if.valid = 1'b0;

        while (owed_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && owed_responses.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
